[sv/ppsky_pkg.sv]
// Package: pipeline slot schedule, per-slot payload type and the CORDIC angle table.
package ppsky_pkg;

  // Largest disc height; datapath widths below are sized for it
  localparam int MAX_HEIGHT = 4096;

  // CORDIC datapath width: 17-bit folded offset scaled by 2^32, plus growth
  localparam int XW = 52;

  // Slot schedule of the pipeline
  localparam int SLOT_PREP   = 0;
  localparam int SLOT_SQ     = 1;
  localparam int SLOT_SUM    = 2;
  localparam int SQRT_FIRST  = 3;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_FIRST   = SQRT_FIRST + SQRT_STEPS;
  localparam int DIV_STEPS   = 19;
  localparam int SLOT_OUT    = DIV_FIRST + DIV_STEPS;
  localparam int NUM_SLOTS   = SLOT_OUT + 1;
  localparam int MAX_CORDIC  = 32;

  localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;
  localparam logic [31:0] RA_ROUND      = 32'h0000_0800;
  localparam logic signed [19:0] DEC_POLE = 20'sd262144;

  typedef struct packed {
    logic                 north;
    logic                 keep;
    logic                 axis;
    logic [31:0]          axis_ang;
    logic signed [15:0]   dx;
    logic signed [15:0]   dy;
    logic [31:0]          sqx;
    logic [31:0]          sqy;
    logic [25:0]          hh;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          z;
    logic [61:0]          v;
    logic [34:0]          rem;
    logic [30:0]          root;
    logic [31:0]          dv;
    logic [18:0]          q;
    logic [19:0]          ra;
    logic signed [19:0]   dec;
    logic [15:0]          inten;
  } stage_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    begin
      case (i)
        0:  r = 32'd536870912;
        1:  r = 32'd316933406;
        2:  r = 32'd167458907;
        3:  r = 32'd85004756;
        4:  r = 32'd42667331;
        5:  r = 32'd21354465;
        6:  r = 32'd10679838;
        7:  r = 32'd5340245;
        8:  r = 32'd2670163;
        9:  r = 32'd1335087;
        10: r = 32'd667544;
        11: r = 32'd333772;
        12: r = 32'd166886;
        13: r = 32'd83443;
        14: r = 32'd41722;
        15: r = 32'd20861;
        16: r = 32'd10430;
        17: r = 32'd5215;
        18: r = 32'd2608;
        19: r = 32'd1304;
        20: r = 32'd652;
        21: r = 32'd326;
        22: r = 32'd163;
        23: r = 32'd81;
        24: r = 32'd41;
        25: r = 32'd20;
        26: r = 32'd10;
        27: r = 32'd5;
        28: r = 32'd3;
        29: r = 32'd1;
        30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

[sv/ppsky_slot.sv]
// One pipeline slot: the step that schedule position K performs, plus its register.
module ppsky_slot #(
  parameter int K             = 1,
  parameter int CORDIC_STAGES = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [12:0]      h,
  input  logic             prev_vld,
  input  ppsky_pkg::stage_t prev,
  output logic             vld_r,
  output ppsky_pkg::stage_t st_r
);
  import ppsky_pkg::*;

  localparam int CSH = (K >= 1) ? K - 1 : 0;
  localparam int DJ  = (K >= DIV_FIRST) ? K - DIV_FIRST : 0;
  localparam int DB  = (DJ <= DIV_STEPS - 1) ? DIV_STEPS - 1 - DJ : 0;

  stage_t               st_nxt;
  logic                 vld_nxt;
  logic signed [XW-1:0] xs, ys;
  logic [34:0]          r2, trial;
  logic [31:0]          dvin, hs;
  logic [18:0]          qb;
  logic [32:0]          s33;
  logic [31:0]          ang, phi, phr;

  always_comb begin
    st_nxt  = prev;
    vld_nxt = prev_vld;
    xs = prev.x >>> CSH;
    ys = prev.y >>> CSH;
    r2    = {prev.rem[32:0], prev.v[61:60]};
    trial = {2'b00, prev.root, 2'b01};
    dvin  = (DJ == 0) ? {1'b0, prev.root} : prev.dv;
    qb    = (DJ == 0) ? 19'd0 : prev.q;
    hs    = {19'd0, h} << DB;
    s33   = {1'b0, prev.sqx} + {1'b0, prev.sqy};
    ang   = prev.axis ? prev.axis_ang : prev.z;
    phi   = prev.north ? (TURN_3QUARTER - ang) : (ang + TURN_QUARTER);
    phr   = phi + RA_ROUND;

    // CORDIC vectoring micro-rotation
    if (K >= 1 && K <= CORDIC_STAGES) begin
      if (prev.y > 0) begin
        st_nxt.x = prev.x + ys;
        st_nxt.y = prev.y - xs;
        st_nxt.z = prev.z + atan_turn(CSH);
      end else begin
        st_nxt.x = prev.x - ys;
        st_nxt.y = prev.y + xs;
        st_nxt.z = prev.z - atan_turn(CSH);
      end
    end

    if (K == SLOT_SQ) begin
      st_nxt.sqx = $unsigned(32'(prev.dx) * 32'(prev.dx));
      st_nxt.sqy = $unsigned(32'(prev.dy) * 32'(prev.dy));
      st_nxt.hh  = {13'd0, h} * {13'd0, h};
    end else if (K == SLOT_SUM) begin
      // disc test 4s <= h^2, then load sqrt operand s * 2^38
      st_nxt.keep = prev.keep && ({s33, 2'b00} <= {9'd0, prev.hh});
      st_nxt.v    = {s33[23:0], 38'd0};
      st_nxt.rem  = '0;
      st_nxt.root = '0;
    end else if (K >= SQRT_FIRST && K < DIV_FIRST) begin
      // one root bit per slot
      st_nxt.v = {prev.v[59:0], 2'b00};
      if (r2 >= trial) begin
        st_nxt.rem  = r2 - trial;
        st_nxt.root = {prev.root[29:0], 1'b1};
      end else begin
        st_nxt.rem  = r2;
        st_nxt.root = {prev.root[29:0], 1'b0};
      end
    end else if (K >= DIV_FIRST && K < SLOT_OUT) begin
      // restoring division by h, one quotient bit per slot
      st_nxt.q = qb;
      if (dvin >= hs) begin
        st_nxt.dv    = dvin - hs;
        st_nxt.q[DB] = 1'b1;
      end else begin
        st_nxt.dv = dvin;
      end
    end else if (K == SLOT_OUT) begin
      st_nxt.ra  = phr[31:12];
      st_nxt.dec = prev.north ? (DEC_POLE - $signed({1'b0, prev.q}))
                              : ($signed({1'b0, prev.q}) - DEC_POLE);
      vld_nxt = prev_vld && prev.keep;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

[sv/polar_projection_to_sky_coords.sv]
// Top level: two-disc polar sky map pixel to right ascension and declination.
//
//  port group | dir | beat contents
//  in_*       | in  | column, row, intensity
//  out_*      | out | ra_turns, declination, intensity_out
//  cfg_*      | in  | image_height (write only)
//
// One pixel per cycle unless stalled as below: a prep slot, two slots of squares
// and disc test, 31 square-root slots, 19 divide slots and the output register;
// CORDIC runs beside the squares, disc test and square root. Pixels that are zero
// or off-disc leave no beat. Reset clears all valid bits and loads image_height 1024.
// A stall while out_valid is high freezes the whole pipeline and raises in_stall.
module polar_projection_to_sky_coords #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [12:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic [15:0]        in_intensity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        out_ra_turns,
  output logic signed [19:0] out_declination,
  output logic [15:0]        out_intensity_out
);
  import ppsky_pkg::*;

  localparam logic [16:0] MAXH = 17'(MAX_HEIGHT);

  logic [12:0]          height_r;
  logic [12:0]          h_eff, half;
  logic                 adv;
  stage_t               in_st;
  stage_t               st [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld;
  logic                 north;
  logic signed [15:0]   dx, dy;
  logic signed [16:0]   dxf, dyf;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 13'd1024;
    end else if (cfg_we) begin
      height_r <= cfg_wdata;
    end
  end

  assign h_eff    = ({4'd0, height_r} > MAXH) ? MAXH[12:0] : height_r;
  assign half     = h_eff >> 1;
  assign adv      = !(vld[NUM_SLOTS-1] && out_stall);
  assign in_stall = !adv;

  // centre offsets and half-turn fold for the left half-plane
  always_comb begin
    north = in_column < h_eff;
    dx = north ? $signed({3'd0, in_column} - {3'd0, half})
               : $signed({3'd0, in_column} - {3'd0, h_eff} - {3'd0, half});
    dy = $signed({3'd0, h_eff} - {4'd0, in_row} - {3'd0, half});
    dxf = (dx < 0) ? -{dx[15], dx} : {dx[15], dx};
    dyf = (dx < 0) ? -{dy[15], dy} : {dy[15], dy};
    in_st          = '0;
    in_st.north    = north;
    in_st.keep     = (in_intensity != 16'd0) && (h_eff != 13'd0);
    in_st.dx       = dx;
    in_st.dy       = dy;
    in_st.inten    = in_intensity;
    in_st.x        = {{(XW-49){dxf[16]}}, dxf, 32'd0};
    in_st.y        = {{(XW-49){dyf[16]}}, dyf, 32'd0};
    in_st.z        = (dx < 0) ? TURN_HALF : 32'd0;
    in_st.axis     = (dx == 0) || (dy == 0);
    if (dy == 0) begin
      in_st.axis_ang = (dx < 0) ? TURN_HALF : 32'd0;
    end else begin
      in_st.axis_ang = (dy > 0) ? TURN_QUARTER : TURN_3QUARTER;
    end
  end

  // pipeline slots
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    if (k == SLOT_PREP) begin : g_first
      ppsky_slot #(.K(k), .CORDIC_STAGES(CORDIC_STAGES)) u_slot (
        .clk(clk), .rst_n(rst_n), .adv(adv), .h(h_eff),
        .prev_vld(in_valid), .prev(in_st),
        .vld_r(vld[k]), .st_r(st[k])
      );
    end else begin : g_rest
      ppsky_slot #(.K(k), .CORDIC_STAGES(CORDIC_STAGES)) u_slot (
        .clk(clk), .rst_n(rst_n), .adv(adv), .h(h_eff),
        .prev_vld(vld[k-1]), .prev(st[k-1]),
        .vld_r(vld[k]), .st_r(st[k])
      );
    end
  end

  assign out_valid         = vld[NUM_SLOTS-1];
  assign out_ra_turns      = st[NUM_SLOTS-1].ra;
  assign out_declination   = st[NUM_SLOTS-1].dec;
  assign out_intensity_out = st[NUM_SLOTS-1].inten;

  // pipeline freezes while the output beat waits
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld[SQRT_FIRST]) && $stable(vld[DIV_FIRST]))
    else $error("pipeline moved during stall");

  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_declination <= DEC_POLE) && (out_declination >= -DEC_POLE))
    else $error("declination out of range");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_intensity_out != 16'd0)
    else $error("zero pixel produced a beat");

endmodule

[test/tb_top.sv]
// Testbench for polar_projection_to_sky_coords: directed and random pixels vs a local predictor.
module tb_top;
  import ppsky_pkg::*;

  typedef struct {
    logic [19:0] ra;
    logic [19:0] dec;
    logic [15:0] inten;
  } sky_coord_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [12:0] in_column;
  logic [11:0] in_row;
  logic [15:0] in_intensity;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] out_ra_turns;
  logic signed [19:0] out_declination;
  logic [15:0] out_intensity_out;

  // predictor copy of the height register
  logic [12:0] height_reg;
  sky_coord_t  expected_coords[$];
  int          mismatches;
  int          pixels_sent;
  int          coords_seen;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  int          hold_cycles;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_TBL [0:19] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304};

  polar_projection_to_sky_coords dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_column(in_column),
    .in_row(in_row), .in_intensity(in_intensity), .out_valid(out_valid),
    .out_stall(out_stall), .out_ra_turns(out_ra_turns),
    .out_declination(out_declination), .out_intensity_out(out_intensity_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  // Sky position of one pixel; returns 0 when the pixel gives no beat
  function automatic bit sky_position(input logic [12:0] col, input logic [11:0] row,
                                      input logic [15:0] inten, output sky_coord_t c);
    longint h, half, dx, dy, x, y, nx;
    longint unsigned s, v, r, b, q;
    logic [31:0] z, phi;
    bit north;
    h = height_reg;
    c.inten = inten;
    if (h > 4096) h = 4096;
    if (h == 0 || inten == 0) return 0;
    half = h / 2;
    north = (col < h);
    dx = north ? longint'(col) - half : longint'(col) - h - half;
    dy = (h - longint'(row)) - half;
    s = dx * dx + dy * dy;
    if (4 * s > h * h) return 0;
    // polar angle
    if (dy == 0) begin
      z = (dx < 0) ? TURN_HALF : 32'd0;
    end else if (dx == 0) begin
      z = (dy > 0) ? TURN_QUARTER : TURN_3QUARTER;
    end else begin
      z = 32'd0;
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
        z = TURN_HALF;
      end
      x = dx <<< 32;
      y = dy <<< 32;
      for (int i = 0; i < 20; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + ATAN_TBL[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - ATAN_TBL[i];
        end
        x = nx;
      end
    end
    phi = north ? TURN_3QUARTER - z : z + TURN_QUARTER;
    c.ra = 20'((phi + 32'h800) >> 12);
    // radius via integer square root
    v = s << 38;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    q = r / longint'(h);
    c.dec = north ? 20'(262144 - longint'(q)) : 20'(longint'(q) - 262144);
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
    $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, coords_seen);
    mismatches++;
  endtask

  // Receiver stall: long hold-off counter first, else random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Result check, sampled mid-cycle where everything is settled
  always @(negedge clk) begin
    sky_coord_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_coords.size() == 0) begin
        report_mismatch("unexpected beat", out_ra_turns, 20'd0);
      end else begin
        w = expected_coords.pop_front();
        if (out_ra_turns !== w.ra) report_mismatch("ra_turns", out_ra_turns, w.ra);
        if (out_declination !== w.dec) report_mismatch("declination", out_declination, w.dec);
        if (out_intensity_out !== w.inten)
          report_mismatch("intensity_out", 20'(out_intensity_out), 20'(w.inten));
      end
      coords_seen++;
    end
  end

  // Send one pixel; called right after a rising edge, returns at its accepting edge
  task automatic send_pixel(input logic [12:0] col, input logic [11:0] row,
                            input logic [15:0] inten);
    sky_coord_t c;
    bit ok;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_column <= col;
    in_row <= row;
    in_intensity <= inten;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (sky_position(col, row, inten, c)) expected_coords.insert(expected_coords.size(), c);
    pixels_sent++;
  endtask

  task automatic drain;
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (expected_coords.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic set_height(input logic [12:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    height_reg = h;
  endtask

  // Pixel mostly inside the image, sometimes anywhere
  task automatic random_pixel;
    int hh;
    logic [15:0] inten;
    hh = (height_reg > 4096) ? 4096 : (height_reg == 0 ? 1 : height_reg);
    inten = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
    if ($urandom_range(9) < 8)
      send_pixel(13'($urandom_range(2 * hh - 1)), 12'($urandom_range(hh > 4096 ? 4095 : hh - 1)),
                 inten);
    else
      send_pixel(13'($urandom), 12'($urandom), 16'($urandom));
  endtask

  task automatic test_directed;
    set_height(13'd1024);
    send_pixel(13'd512, 12'd512, 16'd1);        // north center
    send_pixel(13'd1536, 12'd512, 16'hFFFF);    // south center
    send_pixel(13'd0, 12'd512, 16'd7);          // north rim, on axis
    send_pixel(13'd1023, 12'd512, 16'd7);
    send_pixel(13'd512, 12'd0, 16'd9);          // top rim
    send_pixel(13'd512, 12'd1023, 16'd9);
    send_pixel(13'd1024, 12'd512, 16'd3);       // south rim
    send_pixel(13'd2047, 12'd512, 16'd3);
    send_pixel(13'd700, 12'd300, 16'd0);        // zero intensity
    send_pixel(13'd0, 12'd0, 16'd5);            // corner, off disc
    send_pixel(13'd8191, 12'd4095, 16'hFFFF);   // far outside
    send_pixel(13'd700, 12'd300, 16'h8000);
    send_pixel(13'd300, 12'd700, 16'h1234);
    send_pixel(13'd1800, 12'd200, 16'h4321);
    set_height(13'd2);                          // smallest normal disc
    send_pixel(13'd1, 12'd1, 16'd1);
    send_pixel(13'd3, 12'd0, 16'd1);
    set_height(13'd1);
    send_pixel(13'd0, 12'd0, 16'd1);
    send_pixel(13'd1, 12'd0, 16'd1);
    set_height(13'd0);                          // no beats at all
    send_pixel(13'd0, 12'd0, 16'd1);
    set_height(13'd8191);                       // saturates to full size
    send_pixel(13'd2048, 12'd2048, 16'd2);
    send_pixel(13'd8191, 12'd2048, 16'd2);
    send_pixel(13'd4096, 12'd4095, 16'd2);
  endtask

  task automatic test_random(input int n);
    logic [12:0] heights[6] = '{13'd4096, 13'd37, 13'd2, 13'd1000, 13'd8191, 13'd513};
    for (int i = 0; i < n; i++) begin
      if (i % 35 == 0) set_height(heights[$urandom_range(5)]);
      random_pixel();
    end
  endtask

  task automatic test_backpressure;
    set_height(13'd4096);
    hold_cycles = 400;
    for (int i = 0; i < 100; i++) random_pixel();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_column = '0;
    in_row = '0;
    in_intensity = '0;
    height_reg = 13'd1024;
    mismatches = 0;
    pixels_sent = 0;
    coords_seen = 0;
    hold_cycles = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    sender_idle_pct = 20;
    receiver_idle_pct = 73;
    test_random(160);
    sender_idle_pct = 73;
    receiver_idle_pct = 20;
    test_random(160);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random(160);
    test_backpressure();
    drain();

    $display("covered %0d pixels and %0d result beats over several disc heights,",
             pixels_sent, coords_seen);
    $display("with random idling on both sides and one long output hold-off");
    if (mismatches == 0 && expected_coords.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[polar_projection_to_sky_coords.f]
sv/ppsky_pkg.sv
sv/ppsky_slot.sv
sv/polar_projection_to_sky_coords.sv
test/tb_top.sv
